@@ hdl/wgt_pkg.sv @@
// Package for the weighted GEMM block: sizes, opcodes, register indexes,
// and the shared round-and-saturate helper. No dependencies.
package wgt_pkg;
	localparam int MAX_DIM   = 8;
	localparam int FRAC_BITS = 16;
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int ACC_W     = 72;

	typedef logic signed [31:0] word_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam logic [2:0] OP_LOAD_A = 3'd0;
	localparam logic [2:0] OP_LOAD_B = 3'd1;
	localparam logic [2:0] OP_LOAD_C = 3'd2;
	localparam logic [2:0] OP_LOAD_W = 3'd3;
	localparam logic [2:0] OP_START  = 3'd4;

	localparam logic [2:0] REG_ROWS_M  = 3'd0;
	localparam logic [2:0] REG_INNER_K = 3'd1;
	localparam logic [2:0] REG_COLS_N  = 3'd2;
	localparam logic [2:0] REG_ALPHA   = 3'd3;
	localparam logic [2:0] REG_BETA    = 3'd4;
	localparam logic [2:0] REG_TR_L    = 3'd5;
	localparam logic [2:0] REG_TR_R    = 3'd6;
	localparam logic [2:0] REG_USE_W   = 3'd7;

	// Shift right by FRAC_BITS with rounding to nearest (ties up), then saturate.
	function automatic word_t round_sat(input acc_t v);
		acc_t r;
		r = (v + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > acc_t'(32'sh7fffffff)) return 32'sh7fffffff;
		if (r < -acc_t'(33'sh080000000)) return 32'sh80000000;
		return word_t'(r[31:0]);
	endfunction
endpackage

@@ hdl/weighted_gemm_transpose.sv @@
// Top level of the weighted GEMM block: command decode, operand memories,
// and the sequencer around the shared multiplier. Depends on wgt_pkg, wgt_mac.
//
// A start transfer recomputes C = beta*C + alpha*op(A)*diag(w)*op(B) one
// element at a time in column-major order, on one multiplier. Each element
// runs a clear state, then per inner step a read, an optional weight
// multiply and round, a multiply and an accumulate, then the sum rounding,
// the alpha and beta terms and the write-back. Busy is high throughout a run.
// Results appear with done high for one cycle each, registered from the
// write-back state, and cannot be stalled.
module weighted_gemm_transpose (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [5:0]  index,
	input  logic signed [31:0] value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [5:0]  out_index,
	output logic signed [31:0] out_value,
	output logic        last
);
	import wgt_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_RD = 4'd2, S_WMUL = 4'd3,
		S_WACC = 4'd4, S_BMUL = 4'd5, S_BACC = 4'd6, S_AMUL = 4'd7, S_AACC = 4'd8,
		S_CMUL = 4'd9, S_CACC = 4'd10, S_OUT = 4'd11, S_PRE = 4'd12, S_WRD = 4'd13;

	logic [3:0] state_q;
	logic [3:0] rows_q, inner_q, cols_q;
	word_t alpha_q, beta_q;
	logic tl_q, tr_q, uw_q;

	word_t a_mem [DEPTH];
	word_t b_mem [DEPTH];
	word_t c_mem [DEPTH];
	word_t w_mem [MAX_DIM];
	word_t a_rd_q, b_rd_q, c_rd_q, w_rd_q, aw_q, s_q;

	logic [2:0]  op_q;
	logic [5:0]  idx_q;
	word_t       val_q;
	logic [IDX_W-1:0] i_q, j_q, t_q;

	// Effective dimensions: zero acts as one, large values clamp.
	function automatic logic [DIM_W-1:0] eff(input logic [3:0] d);
		if (d == 4'd0) return DIM_W'(1);
		if (32'(d) > MAX_DIM) return DIM_W'(MAX_DIM);
		return DIM_W'(d);
	endfunction
	logic [DIM_W-1:0] m_e, k_e, n_e;
	assign m_e = eff(rows_q);
	assign k_e = eff(inner_q);
	assign n_e = eff(cols_q);

	logic [ADDR_W-1:0] a_addr, b_addr, c_addr;
	always_comb begin
		a_addr = tl_q ? ADDR_W'(32'(i_q) * 32'(k_e) + 32'(t_q))
			: ADDR_W'(32'(t_q) * 32'(m_e) + 32'(i_q));
		b_addr = tr_q ? ADDR_W'(32'(t_q) * 32'(n_e) + 32'(j_q))
			: ADDR_W'(32'(j_q) * 32'(k_e) + 32'(t_q));
		c_addr = ADDR_W'(32'(j_q) * 32'(m_e) + 32'(i_q));
	end

	// Shared multiplier operand selection.
	logic mul_en, acc_clr, acc_add;
	word_t op_a, op_b;
	logic signed [63:0] prod;
	acc_t acc;
	always_comb begin
		mul_en = 1'b0; acc_clr = 1'b0; acc_add = 1'b0;
		op_a = a_rd_q; op_b = b_rd_q;
		unique case (state_q)
			S_WMUL: begin mul_en = 1'b1; op_a = w_rd_q; op_b = a_rd_q; acc_clr = 1'b0; end
			S_BMUL: begin mul_en = 1'b1; op_a = aw_q; op_b = b_rd_q; end
			S_BACC: acc_add = 1'b1;
			S_AMUL: begin mul_en = 1'b1; op_a = alpha_q; op_b = s_q; acc_clr = 1'b1; end
			S_AACC: begin acc_add = 1'b1; mul_en = 1'b1; op_a = beta_q; op_b = c_rd_q; end
			S_CACC: acc_add = 1'b1;
			S_PRE:  acc_clr = 1'b1;
			default: ;
		endcase
	end

	wgt_mac u_mac (.clk, .mul_en, .op_a, .op_b, .acc_clr, .acc_add,
		.prod_q(prod), .acc_q(acc));

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Memories: written at load, C also at write-back; read registered during the run.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			unique case (op_q)
				OP_LOAD_A: a_mem[idx_q] <= val_q;
				OP_LOAD_B: b_mem[idx_q] <= val_q;
				OP_LOAD_C: c_mem[idx_q] <= val_q;
				OP_LOAD_W: if (32'(idx_q) < MAX_DIM) w_mem[idx_q[IDX_W-1:0]] <= val_q;
				default: ;
			endcase
		end
		if (state_q == S_RD) begin
			a_rd_q <= a_mem[a_addr];
			b_rd_q <= b_mem[b_addr];
			w_rd_q <= w_mem[t_q];
			c_rd_q <= c_mem[c_addr];
		end
		if (state_q == S_OUT) c_mem[c_addr] <= out_value;
		if (state_q == S_WACC) aw_q <= round_sat(ACC_W'(prod));
		else if (state_q == S_RD) aw_q <= a_mem[a_addr];
		if (state_q == S_BACC && 32'(t_q) + 1 == 32'(k_e)) s_q <= s_q;
		if (state_q == S_WRD) s_q <= round_sat(acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_q <= 4'd1; inner_q <= 4'd1; cols_q <= 4'd1;
			alpha_q <= 32'sd65536; beta_q <= '0;
			tl_q <= 1'b0; tr_q <= 1'b0; uw_q <= 1'b0;
			i_q <= '0; j_q <= '0; t_q <= '0;
			done <= 1'b0; last <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ROWS_M:  rows_q  <= cfg_data[3:0];
					REG_INNER_K: inner_q <= cfg_data[3:0];
					REG_COLS_N:  cols_q  <= cfg_data[3:0];
					REG_ALPHA:   alpha_q <= cfg_data;
					REG_BETA:    beta_q  <= cfg_data;
					REG_TR_L:    tl_q    <= cfg_data[0];
					REG_TR_R:    tr_q    <= cfg_data[0];
					REG_USE_W:   uw_q    <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (start) begin
					op_q <= opcode; idx_q <= index; val_q <= value;
					i_q <= '0; j_q <= '0; t_q <= '0;
					state_q <= (opcode == OP_START) ? S_PRE : S_LOAD;
				end
				S_LOAD: state_q <= S_IDLE;
				S_PRE:  state_q <= S_RD;
				S_RD:   state_q <= uw_q ? S_WMUL : S_BMUL;
				S_WMUL: state_q <= S_WACC;
				S_WACC: state_q <= S_BMUL;
				S_BMUL: state_q <= S_BACC;
				S_BACC: begin
					// Product is in the accumulator after this edge.
					if (32'(t_q) + 1 == 32'(k_e)) begin
						t_q <= '0;
						state_q <= S_CMUL;
					end else begin
						t_q <= t_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_CMUL: state_q <= S_WRD;
				S_WRD:  state_q <= S_AMUL;
				S_AMUL: state_q <= S_AACC;
				S_AACC: state_q <= S_CACC;
				S_CACC: state_q <= S_OUT;
				S_OUT: begin
					done <= 1'b1;
					out_index <= c_addr;
					last <= (32'(c_addr) == 32'(m_e) * 32'(n_e) - 1);
					if (32'(i_q) + 1 == 32'(m_e)) begin
						i_q <= '0;
						if (32'(j_q) + 1 == 32'(n_e)) state_q <= S_IDLE;
						else begin j_q <= j_q + 1'b1; state_q <= S_PRE; end
					end else begin
						i_q <= i_q + 1'b1; state_q <= S_PRE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_value = round_sat(acc);

	// Checks on the sequencer.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy)) else $error("result without run");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		last && done |=> !done) else $error("result after last");
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(t_q) < 32'(k_e)) else $error("inner index out of range");
endmodule

@@ hdl/wgt_mac.sv @@
// Shared multiply unit with a wide accumulator for the weighted GEMM block.
// Depends on wgt_pkg.
module wgt_mac (
	input  logic           clk,
	input  logic           mul_en,
	input  wgt_pkg::word_t op_a,
	input  wgt_pkg::word_t op_b,
	input  logic           acc_clr,
	input  logic           acc_add,
	output logic signed [63:0] prod_q,
	output wgt_pkg::acc_t  acc_q
);
	import wgt_pkg::*;

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= 64'(op_a) * 64'(op_b);
		if (acc_clr) acc_q <= '0;
		else if (acc_add) acc_q <= acc_q + ACC_W'(prod_q);
	end
endmodule

@@ tb/wgt_checker.sv @@
// Checker for the weighted GEMM block: mirrors the stores and registers,
// predicts every result element and compares it. Depends on wgt_pkg.
module wgt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  opcode,
	input  logic [5:0]  index,
	input  logic signed [31:0] value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        done,
	input  logic [5:0]  out_index,
	input  logic signed [31:0] out_value,
	input  logic        last,
	output int          mismatches,
	output int          outstanding
);
	import wgt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [79:0] wide_t;

	typedef struct packed {
		logic [5:0]         idx;
		logic signed [31:0] val;
		logic               fin;
	} elem_t;

	word_t mat_a [DEPTH];
	word_t mat_b [DEPTH];
	word_t mat_c [DEPTH];
	word_t wvec [MAX_DIM];

	logic [3:0] dim_m, dim_k, dim_n;
	word_t      scale_alpha, scale_beta;
	logic       tr_a, tr_b, weighted;

	elem_t expected_elems [$];

	assign outstanding = expected_elems.size();

	// Shift down by the fraction width, round half up, clamp to 32 bits.
	function automatic word_t shift_clamp(input wide_t v);
		wide_t r;
		r = (v + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > wide_t'(64'sh7fffffff))
			return 32'sh7fffffff;
		if (r < -wide_t'(64'sh80000000))
			return 32'sh80000000;
		return r[31:0];
	endfunction

	function automatic int clip_dim(input logic [3:0] d);
		if (d == 0)
			return 1;
		return (d > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	// Recompute all of C, write it back into the mirror, queue each element.
	task automatic compute_gemm_run();
		int    m, k, n, pos;
		wide_t acc, ax, bx, sx, cx, al, be;
		word_t a, s, nv;
		elem_t e;
		m = clip_dim(dim_m);
		k = clip_dim(dim_k);
		n = clip_dim(dim_n);
		al = wide_t'(scale_alpha);
		be = wide_t'(scale_beta);
		for (int j = 0; j < n; j++) begin
			for (int i = 0; i < m; i++) begin
				pos = j * m + i;
				acc = '0;
				for (int t = 0; t < k; t++) begin
					a = tr_a ? mat_a[i * k + t] : mat_a[t * m + i];
					if (weighted) begin
						ax = wide_t'(a);
						bx = wide_t'(wvec[t]);
						a = shift_clamp(ax * bx);
					end
					ax = wide_t'(a);
					bx = wide_t'(tr_b ? mat_b[t * n + j] : mat_b[j * k + t]);
					acc = acc + ax * bx;
				end
				s = shift_clamp(acc);
				sx = wide_t'(s);
				cx = wide_t'(mat_c[pos]);
				nv = shift_clamp(al * sx + be * cx);
				mat_c[pos] = nv;
				e.idx = pos[5:0];
				e.val = nv;
				e.fin = (pos == m * n - 1);
				expected_elems.push_back(e);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		elem_t e;
		if (!arst_n) begin
			dim_m       <= 4'd1;
			dim_k       <= 4'd1;
			dim_n       <= 4'd1;
			scale_alpha <= 32'sd65536;
			scale_beta  <= 32'sd0;
			tr_a        <= 1'b0;
			tr_b        <= 1'b0;
			weighted    <= 1'b0;
			mismatches  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS_M:  dim_m <= cfg_data[3:0];
					REG_INNER_K: dim_k <= cfg_data[3:0];
					REG_COLS_N:  dim_n <= cfg_data[3:0];
					REG_ALPHA:   scale_alpha <= cfg_data;
					REG_BETA:    scale_beta <= cfg_data;
					REG_TR_L:    tr_a <= cfg_data[0];
					REG_TR_R:    tr_b <= cfg_data[0];
					REG_USE_W:   weighted <= cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (opcode)
					OP_LOAD_A: mat_a[index] = value;
					OP_LOAD_B: mat_b[index] = value;
					OP_LOAD_C: mat_c[index] = value;
					OP_LOAD_W: if (index < MAX_DIM) wvec[index[IDX_W-1:0]] = value;
					OP_START:  compute_gemm_run();
					default: ;
				endcase
			end
			if (done) begin
				if (expected_elems.size() == 0) begin
					$error("result with nothing expected: out_index %0d out_value %0d",
						out_index, out_value);
					mismatches <= mismatches + 1;
				end else begin
					e = expected_elems.pop_front();
					if (out_index !== e.idx || out_value !== e.val || last !== e.fin)
						mismatches <= mismatches + 1;
					if (out_index !== e.idx)
						$error("out_index expected %0d actual %0d", e.idx, out_index);
					if (out_value !== e.val)
						$error("out_value expected %0d actual %0d", e.val, out_value);
					if (last !== e.fin)
						$error("last expected %0d actual %0d", e.fin, last);
				end
			end
		end
	end
endmodule

@@ tb/tb.sv @@
// Top of the weighted GEMM testbench: clock, reset, command and register
// stimulus, watchdog and verdict. Depends on wgt_pkg, wgt_checker and the block.
module tb;
	import wgt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Opcodes that the block must ignore.
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES = 12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  opcode = '0;
	logic [5:0]  index = '0;
	logic signed [31:0] value = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        done;
	logic [5:0]  out_index;
	logic signed [31:0] out_value;
	logic        last;
	int          mismatches;
	int          outstanding;
	int          idle_cycles = 0;
	bit          gaps_on = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	weighted_gemm_transpose u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .index(index), .value(value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .out_index(out_index), .out_value(out_value), .last(last)
	);

	wgt_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .index(index), .value(value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .out_index(out_index), .out_value(out_value), .last(last),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// The watchdog counts cycles in which no transfer of any kind happens.
	// The slowest element of a full 8x8x8 weighted run finishes well within this
	// limit, so the limit only trips on a hang.
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Element values: small numbers so that products stay meaningful, the
	// saturation extremes and fully random words, in equal shares.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3: return $urandom_range(0, 32'h80000) - 32'h40000;
			default: return $urandom;
		endcase
	endfunction

	// One command transfer. A random gap may come first; start then stays high
	// until the block accepts it.
	task automatic send_cmd(input logic [2:0] op, input logic [5:0] idx,
			input logic [31:0] val);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start  <= 1'b1;
		opcode <= op;
		index  <= idx;
		value  <= val;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every expected element has come and the block
	// reports idle. A final wait then covers the tail of a load in flight.
	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] ridx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= ridx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Dimension and flag writes carry random upper bits, which the block must drop.
	task automatic set_config(input int ph);
		logic [3:0]  m, k, n;
		logic [31:0] al, be;
		logic        fl, fr, fw;
		case (ph)
			0: begin
				m = 4'd8; k = 4'd8; n = 4'd8; al = 32'h10000; be = 32'h10000;
				fl = 1'b1; fr = 1'b1; fw = 1'b1;
			end
			1: begin
				m = 4'd1; k = 4'd1; n = 4'd1; al = 32'h7fffffff; be = 32'h80000000;
				fl = 1'b0; fr = 1'b0; fw = 1'b0;
			end
			2: begin
				// Zero acts as one, anything above eight acts as eight.
				m = 4'd0; k = 4'd15; n = 4'd9; al = 32'h80000000; be = 32'h7fffffff;
				fl = 1'b1; fr = 1'b0; fw = 1'b1;
			end
			default: begin
				m = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 8));
				k = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 8));
				n = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 8));
				al = pick_word();
				be = pick_word();
				fl = 1'($urandom); fr = 1'($urandom); fw = 1'($urandom);
			end
		endcase
		write_reg(REG_ROWS_M, {$urandom} << 4 | 32'(m));
		write_reg(REG_INNER_K, {$urandom} << 4 | 32'(k));
		write_reg(REG_COLS_N, {$urandom} << 4 | 32'(n));
		write_reg(REG_ALPHA, al);
		write_reg(REG_BETA, be);
		write_reg(REG_TR_L, {$urandom} << 1 | 32'(fl));
		write_reg(REG_TR_R, {$urandom} << 1 | 32'(fr));
		write_reg(REG_USE_W, {$urandom} << 1 | 32'(fw));
	endtask

	initial begin
		int r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every store entry is written once up front, so no run ever reads
		// an entry that holds nothing.
		for (int i = 0; i < DEPTH; i++) begin
			send_cmd(OP_LOAD_A, 6'(i), pick_word());
			send_cmd(OP_LOAD_B, 6'(i), pick_word());
			send_cmd(OP_LOAD_C, 6'(i), pick_word());
		end
		for (int i = 0; i < MAX_DIM; i++)
			send_cmd(OP_LOAD_W, 6'(i), pick_word());

		// Directed part, under the reset register values: a 1x1x1 product.
		send_cmd(OP_LOAD_A, 6'd0, 32'h7fffffff);
		send_cmd(OP_LOAD_B, 6'd0, 32'h7fffffff);
		send_cmd(OP_START, 6'd0, 32'h0);
		send_cmd(OP_LOAD_A, 6'd0, 32'h80000000);
		send_cmd(OP_START, 6'd63, 32'hffffffff);
		send_cmd(OP_LOAD_B, 6'd0, 32'h80000000);
		send_cmd(OP_START, 6'd0, 32'h0);
		send_cmd(OP_LOAD_C, 6'd63, 32'h80000000);
		send_cmd(OP_LOAD_A, 6'd63, 32'h0);
		send_cmd(OP_LOAD_B, 6'd63, 32'hffffffff);
		send_cmd(OP_LOAD_W, 6'd7, 32'h7fffffff);
		// Weight loads beyond the vector and reserved opcodes are ignored.
		send_cmd(OP_LOAD_W, 6'd8, 32'h12345678);
		send_cmd(OP_LOAD_W, 6'd63, 32'hffffffff);
		send_cmd(OP_RSVD_5, 6'd63, 32'hffffffff);
		send_cmd(OP_RSVD_6, 6'd0, 32'h0);
		send_cmd(OP_RSVD_7, 6'd42, 32'h55aa55aa);
		send_cmd(OP_START, 6'd21, 32'h0);
		wait_quiet();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_config(ph);
			// The last stretch of the run goes without gaps.
			gaps_on = (ph < PHASES - 2);
			for (int it = 0; it < 10; it++) begin
				// Once, the sender holds off until every element is back.
				if (ph == 3 && it == 5)
					wait_quiet();
				r = $urandom_range(0, 9);
				if (r == 0)
					send_cmd(OP_START, 6'($urandom), $urandom);
				else if (r == 1)
					send_cmd(3'($urandom_range(OP_RSVD_5, OP_RSVD_7)), 6'($urandom),
						$urandom);
				else
					send_cmd(3'($urandom_range(OP_LOAD_A, OP_LOAD_W)), 6'($urandom),
						pick_word());
			end
			// Every phase ends on a run so that its setting is exercised.
			send_cmd(OP_START, 6'($urandom), $urandom);
			wait_quiet();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
